>>> src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by deq_ram and double_ended_queue.
package deq_pkg;

  // Width of one stored value.
  localparam int unsigned DataW = 32;

  // Default number of entries in the ring.
  localparam int unsigned DefaultDepth = 16;

  // Width of the entry_count result field.
  localparam int unsigned CountOutW = 5;

  // Request codes; codes 6 and 7 act as a query.
  typedef enum logic [2:0] {
    ReqPushFront = 3'd0,
    ReqPushBack  = 3'd1,
    ReqPopFront  = 3'd2,
    ReqPopBack   = 3'd3,
    ReqQuery     = 3'd4,
    ReqClear     = 3'd5
  } req_e;

endpackage

>>> src/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values (top level).
// Depends on deq_pkg and deq_ram.
//
// Each request transfer pushes at the front or back, pops from the front or
// back, clears, or only queries; every request yields exactly one result
// transfer with the front value, back value, entry count, empty flag and an
// error flag, all taken after the operation. Front and back read -1 when the
// queue is empty. A push on a full queue or a pop on an empty one leaves the
// state alone and sets op_error. Codes 6 and 7 behave as a query. Entries live
// in a ring of DEPTH words in a synchronous memory; front index and count sit
// in flip-flops and reset to zero, the memory itself needs no clearing pass.
// Sequence: a request is taken in StIdle and the memory write happens at that
// edge; the front and back entries are read in StRead, and the result is
// loaded into the output register in StLoad once that register is free. The
// block therefore takes a new request only after the last one has reached the
// output register; the output register lets the next request in while a
// result still waits, and a result still waiting when the next one reaches
// StLoad holds that one off until the output register frees up.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         req_type_i,
  input  logic signed [deq_pkg::DataW-1:0]   data_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [deq_pkg::DataW-1:0]   front_value_o,
  output logic signed [deq_pkg::DataW-1:0]   back_value_o,
  output logic [deq_pkg::CountOutW-1:0]      entry_count_o,
  output logic                               is_empty_o,
  output logic                               op_error_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned ExtW = CntW + deq_pkg::CountOutW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StLoad = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;

  logic in_fire;
  logic out_load;

  // memory signals
  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  logic                      mem_re;
  logic [IdxW-1:0]           mem_raddr_b;
  logic [deq_pkg::DataW-1:0] mem_rdata_a, mem_rdata_b;

  // ring arithmetic
  logic [SumW-1:0] push_sum;
  logic [SumW-1:0] back_sum;
  logic [CntW-1:0] back_off;
  logic            full;

  // output register
  logic                               out_valid_q;
  logic signed [deq_pkg::DataW-1:0]   out_front_q, out_back_q;
  logic [deq_pkg::CountOutW-1:0]      out_count_q;
  logic                               out_empty_q;
  logic                               out_err_q;
  logic [ExtW-1:0]                    cnt_ext;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CntW'(DEPTH));

  // Slot behind the back entry; count is below DEPTH whenever it is used.
  always_comb begin
    push_sum = SumW'(front_q) + SumW'(cnt_q);
    if (push_sum >= SumW'(DEPTH)) begin
      push_sum = push_sum - SumW'(DEPTH);
    end
  end

  // Next state of the ring on an accepted request, plus the memory write.
  always_comb begin
    front_d   = front_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    mem_we    = 1'b0;
    mem_waddr = front_q;
    if (in_fire) begin
      err_d = 1'b0;
      unique case (req_type_i)
        deq_pkg::ReqPushFront: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            front_d   = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
            mem_we    = 1'b1;
            mem_waddr = front_d;
            cnt_d     = cnt_q + 1'b1;
          end
        end
        deq_pkg::ReqPushBack: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = push_sum[IdxW-1:0];
            cnt_d     = cnt_q + 1'b1;
          end
        end
        deq_pkg::ReqPopFront: begin
          if (cnt_q == '0) begin
            err_d = 1'b1;
          end else begin
            front_d = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        deq_pkg::ReqPopBack: begin
          if (cnt_q == '0) begin
            err_d = 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        deq_pkg::ReqClear: begin
          front_d = '0;
          cnt_d   = '0;
        end
        default: begin
          // query, and the unused codes
        end
      endcase
    end
  end

  // Back entry address from the updated state; offset pinned at zero when
  // empty so the address stays in range (the data is masked anyway).
  always_comb begin
    back_off = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
    back_sum = SumW'(front_q) + SumW'(back_off);
    if (back_sum >= SumW'(DEPTH)) begin
      back_sum = back_sum - SumW'(DEPTH);
    end
    mem_raddr_b = back_sum[IdxW-1:0];
  end

  assign mem_re   = (state_q == StRead);
  assign out_load = (state_q == StLoad) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StLoad;
      end
      StLoad: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= '0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{deq_pkg::CountOutW{1'b0}}, cnt_q};

  // Result payload; needs no reset.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_front_q <= (cnt_q == '0) ? '1 : mem_rdata_a;
      out_back_q  <= (cnt_q == '0) ? '1 : mem_rdata_b;
      out_count_q <= cnt_ext[deq_pkg::CountOutW-1:0];
      out_empty_q <= (cnt_q == '0);
      out_err_q   <= err_q;
    end
  end

  deq_ram #(
    .Depth (DEPTH),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (data_value_i),
    .re_i      (mem_re),
    .raddr_a_i (front_q),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign out_valid_o   = out_valid_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign op_error_o    = out_err_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q < IdxW'(DEPTH) || DEPTH == (1 << IdxW))
    else $error("front index out of ring");

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRead |=> state_q == StLoad)
    else $error("read cycle not followed by load");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !full && (req_type_i == deq_pkg::ReqPushFront ||
                          req_type_i == deq_pkg::ReqPushBack))
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("accepted push did not grow the count");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second request taken while one is in flight");
`endif

endmodule

>>> src/deq_ram.sv
// Entry store: one write port, two registered read ports.
// Depends on deq_pkg for the data width.
module deq_ram #(
  parameter int unsigned Depth = deq_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [deq_pkg::DataW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_a_i,
  input  logic [AddrW-1:0]           raddr_b_i,
  output logic [deq_pkg::DataW-1:0]  rdata_a_o,
  output logic [deq_pkg::DataW-1:0]  rdata_b_o
);

  logic [deq_pkg::DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data held until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
